// ----- design/monitor_geometry_table_unit_defines.svh -----
// Assertion macros shared by the monitor geometry table design.
`ifndef MONITOR_GEOMETRY_TABLE_UNIT_DEFINES_SVH
`define MONITOR_GEOMETRY_TABLE_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define MGT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never hold outside reset.
`define MGT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- design/mgt_pkg.sv -----
// Types, codes and geometry helpers for the monitor geometry table.
`default_nettype none
package mgt_pkg;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
	} rect_t;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_LOCATE = 2'd1;
	localparam logic [1:0] OP_EDGE   = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_BAD_INDEX = 2'd2;
	localparam logic [1:0] STAT_EMPTY     = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE, S_LD,
		S_MG_I, S_MG_IL, S_MG_IA, S_MG_J, S_MG_JE, S_MG_JA, S_MG_IW,
		S_LC_RD, S_LC_EV, S_LC_MY, S_LC_CMP,
		S_ED_RDM, S_ED_LDM, S_ED_RD, S_ED_EV,
		S_BD_RD, S_BD_EV, S_DONE
	} state_t;

	function automatic logic signed [16:0] x_end(input rect_t r);
		return 17'(r.x) + $signed({2'b00, r.w});
	endfunction

	function automatic logic signed [16:0] y_end(input rect_t r);
		return 17'(r.y) + $signed({2'b00, r.h});
	endfunction

	// Positive-area intersection of two rectangles.
	function automatic logic overlaps(input rect_t a, input rect_t b);
		logic signed [16:0] x0, y0, x1, y1, ax1, bx1, ay1, by1;
		x0 = (a.x > b.x) ? 17'(a.x) : 17'(b.x);
		y0 = (a.y > b.y) ? 17'(a.y) : 17'(b.y);
		ax1 = x_end(a);
		bx1 = x_end(b);
		ay1 = y_end(a);
		by1 = y_end(b);
		x1 = (ax1 < bx1) ? ax1 : bx1;
		y1 = (ay1 < by1) ? ay1 : by1;
		return (x1 > x0) && (y1 > y0);
	endfunction

	// Bit 17 is set when the point lies inside the span; bits 16:0 give the distance.
	function automatic logic [17:0] axis_dist(input logic signed [15:0] p,
			input logic signed [15:0] s, input logic [14:0] sz);
		logic signed [17:0] pe, se, ee, d;
		pe = 18'(p);
		se = 18'(s);
		ee = se + $signed({3'b000, sz});
		if (pe >= se && pe < ee) begin
			d = '0;
			return {1'b1, d[16:0]};
		end
		if (pe < se) d = se - pe;
		else d = pe - ee + 18'sd1;
		return {1'b0, d[16:0]};
	endfunction

	// Flags are ordered left, right, top, bottom from the top bit down.
	function automatic logic [3:0] edge_update(input rect_t m, input rect_t r,
			input logic [3:0] f);
		logic signed [16:0] mx0, my0, mx1, my1, x0, y0, x1, y1;
		logic [3:0] g;
		mx0 = 17'(m.x);
		my0 = 17'(m.y);
		mx1 = x_end(m);
		my1 = y_end(m);
		x0 = 17'(r.x);
		y0 = 17'(r.y);
		x1 = x_end(r);
		y1 = y_end(r);
		g = f;
		if ((y0 >= my0 && y0 < my1) || (y1 > my0 && y1 <= my1)) begin
			if (x0 < mx0) g[3] = 1'b0;
			if (x1 > mx1) g[2] = 1'b0;
		end
		if ((x0 >= mx0 && x0 < mx1) || (x1 > mx0 && x1 <= mx1)) begin
			if (y0 < my0) g[1] = 1'b0;
			if (y1 > my1) g[0] = 1'b0;
		end
		return g;
	endfunction

endpackage
`default_nettype wire

// ----- design/mgt_if.sv -----
// Request and response channel interfaces of the monitor geometry table.
`default_nettype none
interface mgt_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [14:0]        size_w;
	logic [14:0]        size_h;
	logic               last_rect;
	logic [5:0]         which_monitor;

	modport source (output valid, op, pos_x, pos_y, size_w, size_h, last_rect,
		which_monitor, input ready);
	modport sink (input valid, op, pos_x, pos_y, size_w, size_h, last_rect,
		which_monitor, output ready);
endinterface

interface mgt_rsp_if;
	logic               valid;
	logic               ready;
	logic [3:0]         monitor_index;
	logic               is_leftmost;
	logic               is_rightmost;
	logic               is_topmost;
	logic               is_bottommost;
	logic signed [15:0] min_x;
	logic signed [15:0] min_y;
	logic signed [16:0] max_x;
	logic signed [16:0] max_y;
	logic [4:0]         table_count;
	logic [1:0]         status;

	modport source (output valid, monitor_index, is_leftmost, is_rightmost, is_topmost,
		is_bottommost, min_x, min_y, max_x, max_y, table_count, status, input ready);
	modport sink (input valid, monitor_index, is_leftmost, is_rightmost, is_topmost,
		is_bottommost, min_x, min_y, max_x, max_y, table_count, status, output ready);
endinterface
`default_nettype wire

// ----- design/mgt_ram.sv -----
// Generic single write port RAM with registered read.
`default_nettype none
module mgt_ram #(
	parameter int WIDTH = 62,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- design/monitor_geometry_table_unit.sv -----
// Top level of the monitor geometry table.
//
// channel  dir  payload
// req      in   op, pos_x, pos_y, size_w, size_h, last_rect, which_monitor
// rsp      out  monitor_index, edge flags, bounds, table_count, status
//
// One word at a time. Every word ends with a bounds scan over all entries.
// Locate walks the entries, edge query reads the chosen monitor and then walks them,
// a load writes one entry if not full, a merge compares each entry with every later one.
// The table RAM has one read port.
// Reset empties the table and closes any open load; no clearing pass is needed.
// The response register lets the next word start while a response waits.
`default_nettype none
`include "monitor_geometry_table_unit_defines.svh"
module monitor_geometry_table_unit
	import mgt_pkg::*;
#(
	parameter int MAX_MONITORS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	mgt_req_if.sink  req,
	mgt_rsp_if.source rsp
);
	localparam int IW   = (MAX_MONITORS > 1) ? $clog2(MAX_MONITORS) : 1;
	localparam int CW   = $clog2(MAX_MONITORS + 1);
	localparam int CMPW = 7;

	state_t state_q, state_d;

	logic [1:0]         op_q;
	logic signed [15:0] px_q, py_q;
	logic [14:0]        w_q, h_q;
	logic               last_q;
	logic [5:0]         n_q;

	logic [CW-1:0] cnt_q, i_q, j_q, wp_q;
	logic          load_open_q;
	rect_t         cur_q, cand_q, m_q;
	logic [34:0]   best_q;
	logic [33:0]   sq_q;
	logic [16:0]   dy_q;
	logic [IW-1:0] idx_q;
	logic [3:0]    flags_q;
	logic [1:0]    status_q;

	logic signed [15:0] bmin_x_q, bmin_y_q;
	logic signed [16:0] bmax_x_q, bmax_y_q;

	logic        out_valid_q;
	logic [3:0]  o_idx_q, o_flags_q;
	logic signed [15:0] o_min_x_q, o_min_y_q;
	logic signed [16:0] o_max_x_q, o_max_y_q;
	logic [4:0]  o_cnt_q;
	logic [1:0]  o_status_q;

	logic [16:0] mul_a, mul_b;
	logic [33:0] prod_q;

	logic          we;
	logic [IW-1:0] waddr, raddr;
	rect_t         wdata, rdata;

	logic [CW-1:0] ec;
	logic          j_lt, i_lt, ovl, accept;
	logic [17:0]   ax, ay;
	logic [34:0]   sum_sq;
	logic          in_ready;

	assign accept   = req.valid && req.ready;
	assign in_ready = (state_q == S_IDLE);
	assign req.ready = in_ready;
	assign ec   = load_open_q ? cnt_q : '0;
	assign j_lt = (j_q < cnt_q);
	assign i_lt = (i_q < cnt_q);
	assign ovl  = overlaps(cur_q, rdata);
	assign ax   = axis_dist(px_q, rdata.x, rdata.w);
	assign ay   = axis_dist(py_q, rdata.y, rdata.h);
	assign sum_sq = 35'(sq_q) + 35'(prod_q);

	mgt_ram #(.WIDTH($bits(rect_t)), .DEPTH(MAX_MONITORS)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Shared multiplier, always registered.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = IW'(wp_q);
		wdata   = rdata;
		raddr   = j_q[IW-1:0];
		mul_a   = {2'b00, rdata.w};
		mul_b   = {2'b00, rdata.h};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.op)
						OP_LOAD:   state_d = S_LD;
						OP_LOCATE: state_d = (cnt_q == '0) ? S_BD_RD : S_LC_RD;
						OP_EDGE: begin
							if (cnt_q == '0 || CMPW'(req.which_monitor) >= CMPW'(cnt_q))
								state_d = S_BD_RD;
							else
								state_d = S_ED_RDM;
						end
						default: state_d = S_BD_RD;
					endcase
				end
			end
			S_LD: begin
				if (ec < CW'(MAX_MONITORS)) begin
					we    = 1'b1;
					waddr = IW'(ec);
					wdata = '{x: px_q, y: py_q, w: w_q, h: h_q};
				end
				state_d = last_q ? S_MG_I : S_BD_RD;
			end
			S_MG_I: begin
				raddr   = i_q[IW-1:0];
				state_d = i_lt ? S_MG_IL : S_BD_RD;
			end
			S_MG_IL: state_d = S_MG_IA;
			S_MG_IA: state_d = S_MG_J;
			S_MG_J:  state_d = j_lt ? S_MG_JE : S_MG_IW;
			S_MG_JE: begin
				if (ovl) begin
					state_d = S_MG_JA;
				end else begin
					we      = 1'b1;
					state_d = S_MG_J;
				end
			end
			S_MG_JA: state_d = S_MG_J;
			S_MG_IW: begin
				we      = 1'b1;
				waddr   = i_q[IW-1:0];
				wdata   = cur_q;
				state_d = S_MG_I;
			end
			S_LC_RD: state_d = j_lt ? S_LC_EV : S_BD_RD;
			S_LC_EV: begin
				mul_a   = ax[16:0];
				mul_b   = ax[16:0];
				state_d = (ax[17] && ay[17]) ? S_BD_RD : S_LC_MY;
			end
			S_LC_MY: begin
				mul_a   = dy_q;
				mul_b   = dy_q;
				state_d = S_LC_CMP;
			end
			S_LC_CMP: state_d = S_LC_RD;
			S_ED_RDM: begin
				raddr   = IW'(n_q);
				state_d = S_ED_LDM;
			end
			S_ED_LDM: state_d = S_ED_RD;
			S_ED_RD:  state_d = j_lt ? S_ED_EV : S_BD_RD;
			S_ED_EV:  state_d = S_ED_RD;
			S_BD_RD:  state_d = j_lt ? S_BD_EV : S_DONE;
			S_BD_EV:  state_d = S_BD_RD;
			S_DONE: begin
				if (!out_valid_q || rsp.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			load_open_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && (!out_valid_q || rsp.ready)) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			if (state_q == S_LD) begin
				load_open_q <= !last_q;
				cnt_q <= (ec < CW'(MAX_MONITORS)) ? ec + CW'(1) : ec;
			end
			if (state_q == S_MG_IW) cnt_q <= wp_q;
		end
	end

	always_ff @(posedge clk) begin
		// Every path into the bounds scan, the locate walk or the edge walk starts at entry zero.
		if ((state_d == S_BD_RD && state_q != S_BD_EV) || state_d == S_LC_RD && state_q == S_IDLE
				|| state_q == S_ED_LDM) begin
			j_q <= '0;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q     <= req.op;
					px_q     <= req.pos_x;
					py_q     <= req.pos_y;
					w_q      <= req.size_w;
					h_q      <= req.size_h;
					last_q   <= req.last_rect;
					n_q      <= req.which_monitor;
					idx_q    <= '0;
					status_q <= STAT_OK;
					flags_q  <= (req.op == OP_EDGE) ? 4'hF : 4'h0;
					if (req.op == OP_LOCATE && cnt_q == '0) status_q <= STAT_EMPTY;
					if (req.op == OP_EDGE) begin
						if (cnt_q == '0) status_q <= STAT_EMPTY;
						else if (CMPW'(req.which_monitor) >= CMPW'(cnt_q))
							status_q <= STAT_BAD_INDEX;
					end
				end
			end
			S_LD: begin
				if (!(ec < CW'(MAX_MONITORS))) status_q <= STAT_FULL;
				i_q <= '0;
			end
			S_MG_IL: cur_q <= rdata;
			S_MG_IA: begin
				best_q <= 35'(prod_q);
				j_q    <= i_q + CW'(1);
				wp_q   <= i_q + CW'(1);
			end
			S_MG_JE: begin
				cand_q <= rdata;
				if (!ovl) begin
					wp_q <= wp_q + CW'(1);
					j_q  <= j_q + CW'(1);
				end
			end
			S_MG_JA: begin
				if (35'(prod_q) > best_q) begin
					best_q <= 35'(prod_q);
					cur_q  <= cand_q;
				end
				j_q <= j_q + CW'(1);
			end
			S_MG_IW: i_q <= i_q + CW'(1);
			S_LC_EV: begin
				dy_q <= ay[16:0];
				if (ax[17] && ay[17]) idx_q <= j_q[IW-1:0];
			end
			S_LC_MY: sq_q <= prod_q;
			S_LC_CMP: begin
				if (j_q == '0 || sum_sq < best_q) begin
					best_q <= sum_sq;
					idx_q  <= j_q[IW-1:0];
				end
				j_q <= j_q + CW'(1);
			end
			S_ED_LDM: m_q <= rdata;
			S_ED_EV: begin
				if (CMPW'(j_q) != CMPW'(n_q)) flags_q <= edge_update(m_q, rdata, flags_q);
				j_q <= j_q + CW'(1);
			end
			S_BD_RD: begin
				if (j_q == '0) begin
					bmin_x_q <= '0;
					bmin_y_q <= '0;
					bmax_x_q <= '0;
					bmax_y_q <= '0;
				end
			end
			S_BD_EV: begin
				if (j_q == '0 || rdata.x < bmin_x_q) bmin_x_q <= rdata.x;
				if (j_q == '0 || rdata.y < bmin_y_q) bmin_y_q <= rdata.y;
				if (j_q == '0 || x_end(rdata) > bmax_x_q) bmax_x_q <= x_end(rdata);
				if (j_q == '0 || y_end(rdata) > bmax_y_q) bmax_y_q <= y_end(rdata);
				j_q <= j_q + CW'(1);
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					o_idx_q    <= (op_q == OP_LOCATE) ? 4'(idx_q) : 4'h0;
					o_flags_q  <= flags_q;
					o_min_x_q  <= bmin_x_q;
					o_min_y_q  <= bmin_y_q;
					o_max_x_q  <= bmax_x_q;
					o_max_y_q  <= bmax_y_q;
					o_cnt_q    <= 5'(cnt_q);
					o_status_q <= status_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.monitor_index = o_idx_q;
	assign rsp.is_leftmost   = o_flags_q[3];
	assign rsp.is_rightmost  = o_flags_q[2];
	assign rsp.is_topmost    = o_flags_q[1];
	assign rsp.is_bottommost = o_flags_q[0];
	assign rsp.min_x         = o_min_x_q;
	assign rsp.min_y         = o_min_y_q;
	assign rsp.max_x         = o_max_x_q;
	assign rsp.max_y         = o_max_y_q;
	assign rsp.table_count   = o_cnt_q;
	assign rsp.status        = o_status_q;

	`MGT_NEVER(a_cnt_range, CMPW'(cnt_q) > CMPW'(MAX_MONITORS), "entry count beyond capacity")
	`MGT_IMPLIES(a_busy_after_accept, accept, ##1 (state_q != S_IDLE), "idle right after accept")
	`MGT_IMPLIES(a_bad_index_flags, rsp.valid && rsp.status == STAT_BAD_INDEX,
		rsp.is_leftmost && rsp.is_rightmost && rsp.is_topmost && rsp.is_bottommost,
		"bad index response without all edge flags")
endmodule
`default_nettype wire

// ----- tb/mgt_geometry_checker.sv -----
// Checker that predicts every response of the monitor geometry table and compares it.
`timescale 1ns / 100ps
`default_nettype none
module mgt_geometry_checker
	import mgt_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	mgt_req_if       req,
	mgt_rsp_if       rsp,
	output int       fail_count,
	output int       pending,
	output int       compared
);

	typedef struct {
		logic [3:0]         index;
		logic               left;
		logic               right;
		logic               top;
		logic               bottom;
		logic signed [15:0] lo_x;
		logic signed [15:0] lo_y;
		logic signed [16:0] hi_x;
		logic signed [16:0] hi_y;
		logic [4:0]         count;
		logic [1:0]         stat;
	} answer_t;

	int      geo_x[TABLE_DEPTH];
	int      geo_y[TABLE_DEPTH];
	int      geo_w[TABLE_DEPTH];
	int      geo_h[TABLE_DEPTH];
	int      geo_count;
	bit      geo_open;
	answer_t answers_due[$];

	assign pending = answers_due.size();

	function automatic bit rects_overlap(int a, int b);
		int x0, y0, x1, y1;
		x0 = (geo_x[a] > geo_x[b]) ? geo_x[a] : geo_x[b];
		y0 = (geo_y[a] > geo_y[b]) ? geo_y[a] : geo_y[b];
		x1 = (geo_x[a] + geo_w[a] < geo_x[b] + geo_w[b]) ? geo_x[a] + geo_w[a]
			: geo_x[b] + geo_w[b];
		y1 = (geo_y[a] + geo_h[a] < geo_y[b] + geo_h[b]) ? geo_y[a] + geo_h[a]
			: geo_y[b] + geo_h[b];
		return x1 > x0 && y1 > y0;
	endfunction

	function automatic void copy_rect(int dst, int src);
		geo_x[dst] = geo_x[src];
		geo_y[dst] = geo_y[src];
		geo_w[dst] = geo_w[src];
		geo_h[dst] = geo_h[src];
	endfunction

	// Later overlapping entries fold into the earlier one; the larger area keeps its shape.
	function automatic void merge_overlaps();
		longint best, ar;
		int j;
		for (int i = 0; i < geo_count; i++) begin
			best = longint'(geo_w[i]) * geo_h[i];
			j = i + 1;
			while (j < geo_count) begin
				if (rects_overlap(i, j)) begin
					ar = longint'(geo_w[j]) * geo_h[j];
					if (ar > best) begin
						best = ar;
						copy_rect(i, j);
					end
					for (int k = j; k + 1 < geo_count; k++)
						copy_rect(k, k + 1);
					geo_count--;
				end else begin
					j++;
				end
			end
		end
	endfunction

	function automatic longint span_dist(longint p, longint s, longint sz);
		if (p >= s && p < s + sz)
			return 0;
		if (p < s)
			return s - p;
		return p - (s + sz - 1);
	endfunction

	function automatic int nearest_monitor(int px, int py);
		longint dx, dy, d, best;
		int best_i;
		best = 0;
		best_i = 0;
		for (int i = 0; i < geo_count; i++) begin
			dx = span_dist(px, geo_x[i], geo_w[i]);
			dy = span_dist(py, geo_y[i], geo_h[i]);
			if (dx == 0 && dy == 0)
				return i;
			d = dx * dx + dy * dy;
			if (i == 0 || d < best) begin
				best = d;
				best_i = i;
			end
		end
		return best_i;
	endfunction

	function automatic void edge_flags(int n, ref answer_t a);
		int mx0, my0, mx1, my1, x0, y0, x1, y1;
		mx0 = geo_x[n];
		my0 = geo_y[n];
		mx1 = geo_x[n] + geo_w[n];
		my1 = geo_y[n] + geo_h[n];
		for (int i = 0; i < geo_count; i++) begin
			if (i == n)
				continue;
			x0 = geo_x[i];
			y0 = geo_y[i];
			x1 = x0 + geo_w[i];
			y1 = y0 + geo_h[i];
			if ((y0 >= my0 && y0 < my1) || (y1 > my0 && y1 <= my1)) begin
				if (x0 < mx0) a.left = 1'b0;
				if (x1 > mx1) a.right = 1'b0;
			end
			if ((x0 >= mx0 && x0 < mx1) || (x1 > mx0 && x1 <= mx1)) begin
				if (y0 < my0) a.top = 1'b0;
				if (y1 > my1) a.bottom = 1'b0;
			end
		end
	endfunction

	function automatic answer_t predict_geometry(logic [1:0] op, int px, int py, int w,
			int h, bit last, int which);
		answer_t a;
		int mnx, mny, mxx, mxy;
		a = '{default: '0};
		mnx = 0;
		mny = 0;
		mxx = 0;
		mxy = 0;
		case (op)
			OP_LOAD: begin
				if (!geo_open) begin
					geo_count = 0;
					geo_open = 1'b1;
				end
				if (geo_count < TABLE_DEPTH) begin
					geo_x[geo_count] = px;
					geo_y[geo_count] = py;
					geo_w[geo_count] = w;
					geo_h[geo_count] = h;
					geo_count++;
				end else begin
					a.stat = STAT_FULL;
				end
				if (last) begin
					merge_overlaps();
					geo_open = 1'b0;
				end
			end
			OP_LOCATE: begin
				if (geo_count == 0) a.stat = STAT_EMPTY;
				else a.index = 4'(nearest_monitor(px, py));
			end
			OP_EDGE: begin
				a.left = 1'b1;
				a.right = 1'b1;
				a.top = 1'b1;
				a.bottom = 1'b1;
				if (geo_count == 0) a.stat = STAT_EMPTY;
				else if (which >= geo_count) a.stat = STAT_BAD_INDEX;
				else edge_flags(which, a);
			end
			default: ;
		endcase
		for (int i = 0; i < geo_count; i++) begin
			if (i == 0 || geo_x[i] < mnx) mnx = geo_x[i];
			if (i == 0 || geo_y[i] < mny) mny = geo_y[i];
			if (i == 0 || geo_x[i] + geo_w[i] > mxx) mxx = geo_x[i] + geo_w[i];
			if (i == 0 || geo_y[i] + geo_h[i] > mxy) mxy = geo_y[i] + geo_h[i];
		end
		a.lo_x = 16'(mnx);
		a.lo_y = 16'(mny);
		a.hi_x = 17'(mxx);
		a.hi_y = 17'(mxy);
		a.count = 5'(geo_count);
		return a;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t a;
		if (!arst_n) begin
			geo_count = 0;
			geo_open = 1'b0;
			fail_count = 0;
			compared = 0;
			answers_due.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (answers_due.size() == 0) begin
					$error("response word with no request outstanding");
					fail_count++;
				end else begin
					a = answers_due.pop_front();
					compared++;
					check_field("monitor_index", a.index, rsp.monitor_index);
					check_field("is_leftmost", a.left, rsp.is_leftmost);
					check_field("is_rightmost", a.right, rsp.is_rightmost);
					check_field("is_topmost", a.top, rsp.is_topmost);
					check_field("is_bottommost", a.bottom, rsp.is_bottommost);
					check_field("min_x", a.lo_x, rsp.min_x);
					check_field("min_y", a.lo_y, rsp.min_y);
					check_field("max_x", a.hi_x, rsp.max_x);
					check_field("max_y", a.hi_y, rsp.max_y);
					check_field("table_count", a.count, rsp.table_count);
					check_field("status", a.stat, rsp.status);
				end
			end
			if (req.valid && req.ready)
				answers_due.push_back(predict_geometry(req.op, req.pos_x, req.pos_y,
					req.size_w, req.size_h, req.last_rect, req.which_monitor));
		end
	end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Stimulus, clocking and verdict for the monitor geometry table testbench.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import mgt_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 6000;
	localparam int RANDOM_WORDS = 1150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count, pending, compared;
	int   idle_cycles = 0;
	int   burst_left = 0;
	int   sent = 0;
	int   op_sent[4] = '{default: 0};

	mgt_req_if req ();
	mgt_rsp_if rsp ();

	monitor_geometry_table_unit DUT (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	mgt_geometry_checker checker_inst (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fail_count(fail_count), .pending(pending), .compared(compared));

	always #4 clk = ~clk;

	// No accepted word on either channel for too long means the block has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no word accepted for %0d cycles", IDLE_LIMIT);
				$display("monitor_geometry_table_unit regression: fail");
				$finish;
			end
		end
	end

	// Receiver alternates between calm stretches and stretches of random stalls.
	int stall_phase = 0;
	int stall_pct = 0;
	always @(negedge clk) begin
		if (stall_phase == 0) begin
			stall_phase = $urandom_range(5, 60);
			stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 85);
		end
		stall_phase--;
		rsp.ready = arst_n && ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic send_word(logic [1:0] op, logic signed [15:0] px, logic signed [15:0] py,
			logic [14:0] w, logic [14:0] h, logic last, logic [5:0] which);
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		req.valid = 1'b1;
		req.op = op;
		req.pos_x = px;
		req.pos_y = py;
		req.size_w = w;
		req.size_h = h;
		req.last_rect = last;
		req.which_monitor = which;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
		req.valid = 1'b0;
		sent++;
		op_sent[op]++;
	endtask

	task automatic load_rect(int px, int py, int w, int h, bit last);
		send_word(OP_LOAD, 16'(px), 16'(py), 15'(w), 15'(h), last, 6'($urandom));
	endtask

	// Mostly a crowded desktop so overlaps and shared rows are common.
	task automatic random_load(bit last);
		if ($urandom_range(0, 5) == 0)
			send_word(OP_LOAD, 16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
				last, 6'($urandom));
		else
			load_rect($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
				$urandom_range(0, 250), $urandom_range(0, 250), last);
	endtask

	task automatic random_query();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			send_word(OP_UNUSED, 16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
				1'($urandom), 6'($urandom));
		else if (pick < 10)
			send_word(OP_LOCATE, ($urandom_range(0, 3) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 900) - 450), ($urandom_range(0, 3) == 0)
				? 16'($urandom) : 16'($urandom_range(0, 900) - 450), 15'($urandom),
				15'($urandom), 1'($urandom), 6'($urandom));
		else
			send_word(OP_EDGE, 16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
				1'($urandom), ($urandom_range(0, 4) == 0) ? 6'($urandom)
				: 6'($urandom_range(0, 17)));
	endtask

	initial begin
		int n;
		req.valid = 1'b0;
		req.op = OP_LOAD;
		req.pos_x = '0;
		req.pos_y = '0;
		req.size_w = '0;
		req.size_h = '0;
		req.last_rect = 1'b0;
		req.which_monitor = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Queries against the empty table, including the unused op.
		send_word(OP_LOCATE, 16'sd5, -16'sd5, '0, '0, 1'b0, '0);
		send_word(OP_EDGE, '0, '0, '0, '0, 1'b0, 6'd0);
		send_word(OP_UNUSED, -16'sd1, -16'sd1, '1, '1, 1'b1, '1);
		// Extreme corners, a locate while the load is still open, then a zero-size close.
		load_rect(-32768, -32768, 32767, 32767, 1'b0);
		load_rect(32767, 32767, 32767, 32767, 1'b0);
		send_word(OP_LOCATE, '0, '0, '0, '0, 1'b0, '0);
		load_rect(0, 0, 0, 0, 1'b1);
		send_word(OP_EDGE, '0, '0, '0, '0, 1'b0, 6'd0);
		send_word(OP_EDGE, '0, '0, '0, '0, 1'b0, 6'd2);
		send_word(OP_EDGE, '0, '0, '0, '0, 1'b0, 6'd3);
		send_word(OP_EDGE, '0, '0, '0, '0, 1'b0, 6'd63);
		send_word(OP_LOCATE, 16'sh7FFF, -16'sh8000, '0, '0, 1'b0, '0);
		// Overflowing the table: the seventeenth rectangle is dropped but still closes.
		for (int i = 0; i < 17; i++)
			load_rect(i * 100 - 800, 0, 50, 50, i == 16);
		send_word(OP_LOCATE, 16'sd25, -16'sd100, '0, '0, 1'b0, '0);
		// Second overlap is larger and replaces the first before the third is tested.
		load_rect(0, 0, 100, 100, 1'b0);
		load_rect(50, 50, 200, 200, 1'b0);
		load_rect(240, 240, 5, 5, 1'b1);

		while (sent < RANDOM_WORDS) begin
			if ($urandom_range(0, 3) == 0) begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					random_load(i == n - 1 && $urandom_range(0, 9) != 0);
					if ($urandom_range(0, 7) == 0)
						random_query();
				end
			end else begin
				random_query();
			end
		end

		n = 0;
		while (pending != 0 && n < IDLE_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (400) @(posedge clk);
		$display("Sent %0d words: %0d loads, %0d locates, %0d edge queries, %0d unused op.",
			sent, op_sent[0], op_sent[1], op_sent[2], op_sent[3]);
		$display("Compared %0d responses field by field; %0d still outstanding.",
			compared, pending);
		if (fail_count == 0 && pending == 0)
			$display("monitor_geometry_table_unit regression: pass");
		else
			$display("monitor_geometry_table_unit regression: fail");
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+design
design/mgt_pkg.sv
design/mgt_if.sv
design/mgt_ram.sv
design/monitor_geometry_table_unit.sv
tb/mgt_geometry_checker.sv
tb/tb_top.sv
